FILE: src/nsfc_pkg.sv
// shared types, constants and the byte classifier for the nmea sentence framer/checker
// used by nsfc_front, nsfc_back and nmea_sentence_framer_checker
package nsfc_pkg;

	localparam int COUNT_BITS = 16;
	localparam int MAXP_W     = 16;
	localparam int LEN_W      = 16;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);
	localparam int OUT_DEPTH  = 2;
	localparam int OPTR_W     = $clog2(OUT_DEPTH);
	localparam int OCNT_W     = $clog2(OUT_DEPTH + 1);
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 40;

	localparam logic [MAXP_W-1:0]     MAX_PENDING_RST = 16'd1024;
	localparam logic [COUNT_BITS-1:0] MIN_SENT_LEN    = COUNT_BITS'(6);

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;

	localparam logic [23:0] TAG_GGA = "GGA";
	localparam logic [23:0] TAG_TRA = "TRA";
	localparam logic [23:0] TAG_RMC = "RMC";

	localparam int KF_GGA = 0;
	localparam int KF_TRA = 1;
	localparam int KF_RMC = 2;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_GGA  = 2'd1;
	localparam logic [1:0] KIND_TRA  = 2'd2;
	localparam logic [1:0] KIND_RMC  = 2'd3;

	localparam logic [2:0] VERD_PASS      = 3'd0;
	localparam logic [2:0] VERD_SHORT     = 3'd1;
	localparam logic [2:0] VERD_NO_STAR   = 3'd2;
	localparam logic [2:0] VERD_NO_DIGITS = 3'd3;
	localparam logic [2:0] VERD_MISMATCH  = 3'd4;
	localparam logic [2:0] VERD_SKIPPED   = 3'd5;

	localparam logic OUTCOME_CLOSED  = 1'b0;
	localparam logic OUTCOME_DISCARD = 1'b1;

	typedef enum logic [1:0] {
		MODE_HUNT,
		MODE_HASH,
		MODE_DOLLAR
	} mode_t;

	typedef enum logic [1:0] {
		LEAD_OTHER,
		LEAD_HEX,
		LEAD_SKIP,
		LEAD_MINUS
	} lead_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_cr;
		logic       is_lf;
		logic       is_dollar;
		logic       is_hash;
		logic       is_comma;
		logic       is_star;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_skip;
		logic       is_minus;
	} byte_cls_t;

	typedef struct packed {
		logic                  outcome;
		logic [LEN_W-1:0]      length;
		logic                  has_hash;
		logic [2:0]            verdict;
		logic [7:0]            computed_xor;
		logic [7:0]            given_value;
		logic [1:0]            kind;
	} res_t;

	function automatic byte_cls_t classify(input logic [7:0] c);
		byte_cls_t  k;
		logic [7:0] d;
		k = '0;
		k.ch        = c;
		k.is_cr     = (c == CH_CR);
		k.is_lf     = (c == CH_LF);
		k.is_dollar = (c == CH_DOLLAR);
		k.is_hash   = (c == CH_HASH);
		k.is_comma  = (c == CH_COMMA);
		k.is_star   = (c == CH_STAR);
		k.is_minus  = (c == CH_MINUS);
		k.is_skip   = (c == CH_SPACE) || (c == CH_PLUS) || (c >= CH_TAB && c <= CH_CR);
		d = 8'h00;
		if (c >= "0" && c <= "9") begin
			k.is_hex = 1'b1;
			d = c - 8'h30;
		end else if (c >= "a" && c <= "f") begin
			k.is_hex = 1'b1;
			d = c - 8'h57;
		end else if (c >= "A" && c <= "F") begin
			k.is_hex = 1'b1;
			d = c - 8'h37;
		end
		k.hex_val = d[3:0];
		return k;
	endfunction

endpackage

FILE: src/nsfc_front.sv
// front end: accepts received bytes, classifies them and queues the classified words
// depends on nsfc_pkg
module nsfc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_valid,
	output logic                              s_ready,
	input  logic [nsfc_pkg::IN_DATA_W-1:0]    s_byte,
	output logic                              q_valid,
	input  logic                              q_ready,
	output nsfc_pkg::byte_cls_t               q_cls
);

	nsfc_pkg::byte_cls_t                q_mem [nsfc_pkg::QDEPTH];
	logic [nsfc_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [nsfc_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [nsfc_pkg::QCNT_W-1:0]        cnt_q;
	logic                               push;
	logic                               pop;

	assign s_ready = (cnt_q != nsfc_pkg::QCNT_W'(nsfc_pkg::QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_cls   = q_mem[rd_ptr_q];
	assign push    = s_valid && s_ready;
	assign pop     = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= nsfc_pkg::classify(s_byte);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: src/nsfc_back.sv
// back end: sentence tracking, checksum and kind detection, result buffer
// depends on nsfc_pkg
module nsfc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [nsfc_pkg::MAXP_W-1:0]       max_pending,
	input  logic                              q_valid,
	output logic                              q_ready,
	input  nsfc_pkg::byte_cls_t               q_cls,
	output logic                              m_valid,
	input  logic                              m_ready,
	output nsfc_pkg::res_t                    m_res
);

	typedef struct packed {
		nsfc_pkg::mode_t                 mode;
		logic [nsfc_pkg::COUNT_BITS-1:0] count;
		logic [7:0]                      run_xor;
		logic                            star_seen;
		logic [1:0]                      after_cnt;
		logic [7:0]                      hex_acc;
		logic                            hash_seen;
		logic                            ff_open;
		logic [23:0]                     window;
		logic [2:0]                      kind_flags;
		nsfc_pkg::lead_t                 lead;
		logic                            neg;
	} sent_t;

	function automatic sent_t idle_state();
		sent_t s;
		s = '0;
		s.mode    = nsfc_pkg::MODE_HUNT;
		s.lead    = nsfc_pkg::LEAD_OTHER;
		s.ff_open = 1'b1;
		return s;
	endfunction

	function automatic sent_t open_state(input nsfc_pkg::mode_t m);
		sent_t s;
		s = idle_state();
		s.mode      = m;
		s.count     = nsfc_pkg::COUNT_BITS'(1);
		s.hash_seen = (m == nsfc_pkg::MODE_HASH);
		return s;
	endfunction

	// one sentence byte applied to the running state
	function automatic sent_t content_step(input sent_t s_in, input nsfc_pkg::byte_cls_t b);
		sent_t       s;
		logic [23:0] win;
		s   = s_in;
		win = {s_in.window[15:0], b.ch};
		if (s_in.mode == nsfc_pkg::MODE_HUNT) begin
			if (b.is_dollar) begin
				s = open_state(nsfc_pkg::MODE_DOLLAR);
			end else if (b.is_hash) begin
				s = open_state(nsfc_pkg::MODE_HASH);
			end
		end else if (s_in.mode == nsfc_pkg::MODE_HASH && b.is_dollar) begin
			s = open_state(nsfc_pkg::MODE_DOLLAR);
		end else begin
			if (s_in.count != '1) begin
				s.count = s_in.count + 1'b1;
			end
			if (b.is_hash) begin
				s.hash_seen = 1'b1;
			end
			if (s_in.ff_open) begin
				if (b.is_comma) begin
					s.ff_open = 1'b0;
				end else begin
					s.window = win;
					if (win == nsfc_pkg::TAG_GGA) s.kind_flags[nsfc_pkg::KF_GGA] = 1'b1;
					if (win == nsfc_pkg::TAG_TRA) s.kind_flags[nsfc_pkg::KF_TRA] = 1'b1;
					if (win == nsfc_pkg::TAG_RMC) s.kind_flags[nsfc_pkg::KF_RMC] = 1'b1;
				end
			end
			if (!s_in.star_seen) begin
				if (b.is_star) begin
					s.star_seen = 1'b1;
				end else begin
					s.run_xor = s_in.run_xor ^ b.ch;
				end
			end else if (s_in.after_cnt == 2'd0) begin
				// first byte after the star picks how the digits are read
				if (b.is_hex) begin
					s.lead    = nsfc_pkg::LEAD_HEX;
					s.hex_acc = {4'h0, b.hex_val};
				end else if (b.is_skip) begin
					s.lead = nsfc_pkg::LEAD_SKIP;
				end else if (b.is_minus) begin
					s.lead = nsfc_pkg::LEAD_MINUS;
				end else begin
					s.lead = nsfc_pkg::LEAD_OTHER;
				end
				s.after_cnt = 2'd1;
			end else if (s_in.after_cnt == 2'd1) begin
				case (s_in.lead)
					nsfc_pkg::LEAD_HEX: begin
						if (b.is_hex) s.hex_acc = {s_in.hex_acc[3:0], b.hex_val};
					end
					nsfc_pkg::LEAD_SKIP: begin
						s.hex_acc = b.is_hex ? {4'h0, b.hex_val} : 8'h00;
					end
					nsfc_pkg::LEAD_MINUS: begin
						if (b.is_hex && b.hex_val != 4'h0) begin
							s.neg     = 1'b1;
							s.hex_acc = 8'h00 - {4'h0, b.hex_val};
						end else begin
							s.hex_acc = 8'h00;
						end
					end
					default: begin
						s.hex_acc = 8'h00;
					end
				endcase
				s.after_cnt = 2'd2;
			end
		end
		return s;
	endfunction

	function automatic nsfc_pkg::res_t close_res(input sent_t s);
		nsfc_pkg::res_t r;
		r = '0;
		r.outcome      = nsfc_pkg::OUTCOME_CLOSED;
		r.length       = nsfc_pkg::LEN_W'(s.count);
		r.has_hash     = s.hash_seen;
		r.computed_xor = s.run_xor;
		r.given_value  = (s.after_cnt == 2'd2) ? s.hex_acc : 8'h00;
		if (s.hash_seen) begin
			r.verdict = nsfc_pkg::VERD_SKIPPED;
		end else if (s.count < nsfc_pkg::MIN_SENT_LEN) begin
			r.verdict = nsfc_pkg::VERD_SHORT;
		end else if (!s.star_seen) begin
			r.verdict = nsfc_pkg::VERD_NO_STAR;
		end else if (s.after_cnt != 2'd2) begin
			r.verdict = nsfc_pkg::VERD_NO_DIGITS;
		end else if (s.neg || s.hex_acc != s.run_xor) begin
			r.verdict = nsfc_pkg::VERD_MISMATCH;
		end else begin
			r.verdict = nsfc_pkg::VERD_PASS;
		end
		if (s.kind_flags[nsfc_pkg::KF_RMC]) begin
			r.kind = nsfc_pkg::KIND_RMC;
		end else if (s.kind_flags[nsfc_pkg::KF_TRA]) begin
			r.kind = nsfc_pkg::KIND_TRA;
		end else if (s.kind_flags[nsfc_pkg::KF_GGA]) begin
			r.kind = nsfc_pkg::KIND_GGA;
		end else begin
			r.kind = nsfc_pkg::KIND_NONE;
		end
		return r;
	endfunction

	function automatic nsfc_pkg::res_t discard_res();
		nsfc_pkg::res_t r;
		r = '0;
		r.outcome = nsfc_pkg::OUTCOME_DISCARD;
		r.verdict = nsfc_pkg::VERD_SKIPPED;
		r.kind    = nsfc_pkg::KIND_NONE;
		return r;
	endfunction

	sent_t                              st_q;
	sent_t                              st_d;
	sent_t                              s_mid;
	sent_t                              s_fin;
	logic                               cr_q;
	logic                               cr_d;
	logic [nsfc_pkg::COUNT_BITS-1:0]    lc_q;
	logic [nsfc_pkg::COUNT_BITS-1:0]    lc_d;
	logic [nsfc_pkg::COUNT_BITS-1:0]    lc_inc;
	logic                               take;
	logic                               emit;
	nsfc_pkg::res_t                     res_new;

	nsfc_pkg::res_t                     obuf_q [nsfc_pkg::OUT_DEPTH];
	logic [nsfc_pkg::OPTR_W-1:0]        owr_q;
	logic [nsfc_pkg::OPTR_W-1:0]        ord_q;
	logic [nsfc_pkg::OCNT_W-1:0]        ocnt_q;
	logic                               pop;

	assign q_ready = (ocnt_q != nsfc_pkg::OCNT_W'(nsfc_pkg::OUT_DEPTH));
	assign take    = q_valid && q_ready;
	assign m_valid = (ocnt_q != '0);
	assign m_res   = obuf_q[ord_q];
	assign pop     = m_valid && m_ready;
	assign lc_inc  = (lc_q != '1) ? lc_q + 1'b1 : lc_q;

	always_comb begin
		st_d    = st_q;
		cr_d    = cr_q;
		lc_d    = lc_q;
		emit    = 1'b0;
		res_new = '0;
		// a held cr turns into an ordinary byte when no lf follows
		s_mid   = cr_q ? content_step(st_q, nsfc_pkg::classify(nsfc_pkg::CH_CR)) : st_q;
		s_fin   = q_cls.is_cr ? s_mid : content_step(s_mid, q_cls);
		if (take) begin
			if (cr_q && q_cls.is_lf) begin
				if (st_q.mode != nsfc_pkg::MODE_HUNT) begin
					emit    = 1'b1;
					res_new = close_res(st_q);
				end
				st_d = idle_state();
				cr_d = 1'b0;
				lc_d = '0;
			end else if (lc_inc > max_pending) begin
				st_d    = idle_state();
				cr_d    = 1'b0;
				lc_d    = '0;
				emit    = 1'b1;
				res_new = discard_res();
			end else begin
				st_d = s_fin;
				cr_d = q_cls.is_cr;
				lc_d = lc_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= idle_state();
			cr_q <= 1'b0;
			lc_q <= '0;
		end else begin
			st_q <= st_d;
			cr_q <= cr_d;
			lc_q <= lc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			obuf_q[owr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (emit) begin
				owr_q <= owr_q + 1'b1;
			end
			if (pop) begin
				ord_q <= ord_q + 1'b1;
			end
			case ({emit, pop})
				2'b10:   ocnt_q <= ocnt_q + 1'b1;
				2'b01:   ocnt_q <= ocnt_q - 1'b1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_obuf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= nsfc_pkg::OCNT_W'(nsfc_pkg::OUT_DEPTH))
		else $error("result buffer overfilled");

	a_hunt_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.mode == nsfc_pkg::MODE_HUNT) == (st_q.count == '0))
		else $error("sentence count disagrees with scan mode");

	a_cr_counted: assert property (@(posedge clk) disable iff (!arst_n)
		cr_q |-> (lc_q != '0))
		else $error("held cr not counted in pending bytes");

	a_after_star: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.star_seen |-> (st_q.after_cnt == 2'd0))
		else $error("digits counted before any star");

	a_emit_space: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> take)
		else $error("result produced without a word taken");
`endif

endmodule

FILE: src/nmea_sentence_framer_checker.sv
// path: the word that closes or overflows the line is registered in the classify queue, and its
// result is registered in the result buffer, before the result can be taken on m_axis
// throughput: one byte per cycle sustained; a 4-word classify queue and a 2-entry result
// buffer let either side stall on its own, input stalls once both are full
// reset: asynchronous, active low; clears scanning state and queues, max pending bytes
// returns to 1024
// top level of the framer/checker; depends on nsfc_pkg, nsfc_front and nsfc_back
module nmea_sentence_framer_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [nsfc_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // [7:0] rx_byte
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [15:0] sentence_length, [16] has_hash, [19:17] verdict, [27:20] computed_xor,
	// [35:28] given_value, [37:36] sentence_kind, [39:38] zero
	output logic [nsfc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tuser,   // [0] outcome
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nsfc_pkg::MAXP_W-1:0]         cfg_data
);

	logic [nsfc_pkg::MAXP_W-1:0] max_pending_q;
	logic                        q_valid;
	logic                        q_ready;
	nsfc_pkg::byte_cls_t         q_cls;
	nsfc_pkg::res_t              res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pending_q <= nsfc_pkg::MAX_PENDING_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_pending_q <= cfg_data;
		end
	end

	nsfc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.s_byte  (s_axis_tdata),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_cls   (q_cls)
	);

	nsfc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_pending (max_pending_q),
		.q_valid     (q_valid),
		.q_ready     (q_ready),
		.q_cls       (q_cls),
		.m_valid     (m_axis_tvalid),
		.m_ready     (m_axis_tready),
		.m_res       (res)
	);

	assign m_axis_tdata = {2'b00, res.kind, res.given_value, res.computed_xor,
		res.verdict, res.has_hash, res.length};
	assign m_axis_tuser = res.outcome;

endmodule
